// ===== rtl/bmms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmms_pkg
// Shared types, register codes and helpers of the brick min/max block.
// ----------------------------------------------------------------------------
package bmms_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COORD_W     = 10;
    localparam int OFF_W       = 6;
    localparam int OUT_VOXEL_W = 16;
    localparam int SIM_W       = 17;
    localparam int BG_W        = 16;

    localparam logic [SIM_W-1:0] SIM_MAX = 17'h1FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_DEPTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRICK_EDGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE   = 3'd5;

    // metric codes; every other code selects the midpoint distance
    localparam logic [1:0] MODE_NEARER  = 2'd1;
    localparam logic [1:0] MODE_FARTHER = 2'd2;
    localparam logic [1:0] MODE_RESET   = 2'd3;

    // reset geometry, kept as last index (size minus one)
    localparam logic [COORD_W-1:0] RST_LAST_DIM  = 10'd63;
    localparam logic [OFF_W-1:0]   RST_LAST_EDGE = 6'd7;

    typedef struct packed {
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [COORD_W-1:0] last_z;
        logic [OFF_W-1:0]   last_e;
    } geom_t;

    typedef struct packed {
        logic               first;
        logic               done;
        logic [COORD_W-1:0] org_x;
        logic [COORD_W-1:0] org_y;
        logic [COORD_W-1:0] org_z;
    } scan_tag_t;

    // Map a raw dimension to its last index: zero acts as one, above 1024 as 1024.
    function automatic logic [COORD_W-1:0] clamp_dim(input logic [10:0] v);
        logic [10:0] m;
        begin
            m = v - 11'd1;
            if (v == 11'd0) begin
                return '0;
            end else if (v > 11'd1024) begin
                return 10'd1023;
            end else begin
                return m[COORD_W-1:0];
            end
        end
    endfunction

    // Same for the brick edge, range 1..64.
    function automatic logic [OFF_W-1:0] clamp_edge(input logic [6:0] v);
        logic [6:0] m;
        begin
            m = v - 7'd1;
            if (v == 7'd0) begin
                return '0;
            end else if (v > 7'd64) begin
                return 6'd63;
            end else begin
                return m[OFF_W-1:0];
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bmms_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmms_scan
// Raster position, offsets inside the brick and running store index.
// ----------------------------------------------------------------------------
module bmms_scan #(
    parameter int SLAB_BRICKS = 4096,
    parameter int IDX_W       = 12
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  bmms_pkg::geom_t     geom,
    input  wire                 clear,
    input  wire                 adv,
    output logic [IDX_W-1:0]    idx,
    output bmms_pkg::scan_tag_t tag
);
    import bmms_pkg::*;

    logic [COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [COORD_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic [OFF_W-1:0]   off_x_reg, off_y_reg, off_z_reg;
    logic [OFF_W-1:0]   off_x_next, off_y_next, off_z_next;
    logic [IDX_W-1:0]   idx_reg, idx_next, row_base_reg, row_base_next;
    logic [IDX_W-1:0]   idx_inc;
    logic               x_wrap, y_wrap, z_wrap;
    logic               ex_e, ey_e, ez_e;

    assign x_wrap = pos_x_reg >= geom.last_x;
    assign y_wrap = pos_y_reg >= geom.last_y;
    assign z_wrap = pos_z_reg >= geom.last_z;
    assign ex_e   = off_x_reg >= geom.last_e;
    assign ey_e   = off_y_reg >= geom.last_e;
    assign ez_e   = off_z_reg >= geom.last_e;

    assign idx_inc = (idx_reg == IDX_W'(SLAB_BRICKS - 1)) ? '0 : idx_reg + IDX_W'(1);

    assign idx       = idx_reg;
    assign tag.first = (off_x_reg == '0) && (off_y_reg == '0) && (off_z_reg == '0);
    assign tag.done  = (ex_e || x_wrap) && (ey_e || y_wrap) && (ez_e || z_wrap);
    assign tag.org_x = pos_x_reg - {{(COORD_W-OFF_W){1'b0}}, off_x_reg};
    assign tag.org_y = pos_y_reg - {{(COORD_W-OFF_W){1'b0}}, off_y_reg};
    assign tag.org_z = pos_z_reg - {{(COORD_W-OFF_W){1'b0}}, off_z_reg};

    always_comb begin
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        pos_z_next    = pos_z_reg;
        off_x_next    = off_x_reg;
        off_y_next    = off_y_reg;
        off_z_next    = off_z_reg;
        idx_next      = idx_reg;
        row_base_next = row_base_reg;
        if (x_wrap) begin
            pos_x_next = '0;
            off_x_next = '0;
            if (y_wrap) begin
                pos_y_next    = '0;
                off_y_next    = '0;
                row_base_next = '0;
                idx_next      = '0;
                if (z_wrap) begin
                    pos_z_next = '0;
                    off_z_next = '0;
                end else begin
                    pos_z_next = pos_z_reg + COORD_W'(1);
                    off_z_next = ez_e ? '0 : off_z_reg + OFF_W'(1);
                end
            end else begin
                pos_y_next = pos_y_reg + COORD_W'(1);
                if (ey_e) begin
                    // next brick row starts right after the last brick of this one
                    off_y_next    = '0;
                    row_base_next = idx_inc;
                    idx_next      = idx_inc;
                end else begin
                    off_y_next = off_y_reg + OFF_W'(1);
                    idx_next   = row_base_reg;
                end
            end
        end else begin
            pos_x_next = pos_x_reg + COORD_W'(1);
            if (ex_e) begin
                off_x_next = '0;
                idx_next   = idx_inc;
            end else begin
                off_x_next = off_x_reg + OFF_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            off_x_reg    <= '0;
            off_y_reg    <= '0;
            off_z_reg    <= '0;
            idx_reg      <= '0;
            row_base_reg <= '0;
        end else if (adv) begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            pos_z_reg    <= pos_z_next;
            off_x_reg    <= off_x_next;
            off_y_reg    <= off_y_next;
            off_z_reg    <= off_z_next;
            idx_reg      <= idx_next;
            row_base_reg <= row_base_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bmms_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmms_store
// Per-brick min/max memories with read-modify-write and write forwarding.
// ----------------------------------------------------------------------------
module bmms_store #(
    parameter int SLAB_BRICKS = 4096,
    parameter int IDX_W       = 12,
    parameter int VOXEL_BITS  = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         rd_en,
    input  wire        [IDX_W-1:0]      rd_idx,
    input  wire                         upd_en,
    input  wire        [IDX_W-1:0]      upd_idx,
    input  wire signed [VOXEL_BITS-1:0] upd_value,
    input  wire                         upd_first,
    output logic signed [VOXEL_BITS-1:0] new_min,
    output logic signed [VOXEL_BITS-1:0] new_max
);
    import bmms_pkg::*;

    logic signed [VOXEL_BITS-1:0] min_mem [SLAB_BRICKS];
    logic signed [VOXEL_BITS-1:0] max_mem [SLAB_BRICKS];
    logic signed [VOXEL_BITS-1:0] rd_min_reg, rd_max_reg;
    logic signed [VOXEL_BITS-1:0] fwd_min_reg, fwd_max_reg;
    logic        [IDX_W-1:0]      fwd_idx_reg;
    logic                         fwd_valid_reg;
    logic signed [VOXEL_BITS-1:0] old_min, old_max;
    logic                         use_fwd;

    // The read for the item now in the update stage was issued in the same
    // cycle as the previous update's write, so it missed that write.
    assign use_fwd = fwd_valid_reg && (fwd_idx_reg == upd_idx);
    assign old_min = use_fwd ? fwd_min_reg : rd_min_reg;
    assign old_max = use_fwd ? fwd_max_reg : rd_max_reg;

    always_comb begin
        if (upd_first) begin
            new_min = upd_value;
            new_max = upd_value;
        end else begin
            new_min = (upd_value < old_min) ? upd_value : old_min;
            new_max = (upd_value > old_max) ? upd_value : old_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_en) begin
            min_mem[upd_idx] <= new_min;
            max_mem[upd_idx] <= new_max;
        end
        if (rd_en) begin
            rd_min_reg <= min_mem[rd_idx];
            rd_max_reg <= max_mem[rd_idx];
        end
    end

    // Capture the write that coincides with a read; hold it while that item waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_valid_reg <= upd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_idx_reg <= upd_idx;
            fwd_min_reg <= new_min;
            fwd_max_reg <= new_max;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/brick_min_max_similarity.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brick_min_max_similarity
// Streaming per-brick minimum/maximum with similarity to a background level.
// ----------------------------------------------------------------------------
// Usage:
//   Voxels enter on the s_ channel (valid/ready) in raster order, x fastest,
//   then y, then z. The volume is cut into cubic bricks; every voxel does one
//   read-modify-write of the slab min/max memories at its brick's entry.
//   When a voxel completes a brick, one beat leaves on the m_ channel with the
//   brick origin, min, max and similarity (half units). Other voxels leave
//   nothing.
//   Throughput: one voxel per cycle while s_ready is high, set by the single
//   read port and single write port of each slab memory (read into a register,
//   merge and write from the update stage, forwarding back-to-back same-brick beats).
//   A result beat leaves the output register after the completing voxel's update stage.
//   The cfg_ channel writes registers by index, always ready; write it only
//   while the block is idle. Geometry writes restart the scan at the origin.
//   Reset: scan position returns to the origin and the registers take their
//   defaults; memory contents are left as they are (no clearing pass).
//   Stall: while a result beat waits, voxels keep flowing until another
//   brick completes; that voxel holds in the update stage and s_ready drops.
// ----------------------------------------------------------------------------
module brick_min_max_similarity #(
    parameter int SLAB_BRICKS = 4096,
    parameter int VOXEL_BITS  = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  signed [VOXEL_BITS-1:0]     s_voxel_value,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [bmms_pkg::COORD_W-1:0]     m_origin_x,
    output logic [bmms_pkg::COORD_W-1:0]     m_origin_y,
    output logic [bmms_pkg::COORD_W-1:0]     m_origin_z,
    output logic signed [bmms_pkg::OUT_VOXEL_W-1:0] m_min_value,
    output logic signed [bmms_pkg::OUT_VOXEL_W-1:0] m_max_value,
    output logic [bmms_pkg::SIM_W-1:0]       m_similarity,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [bmms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [bmms_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bmms_pkg::*;

    localparam int IDX_W = (SLAB_BRICKS > 1) ? $clog2(SLAB_BRICKS) : 1;
    localparam int CW    = ((VOXEL_BITS > BG_W) ? VOXEL_BITS : BG_W) + 3;

    // ---------------- configuration ----------------
    geom_t                  geom_reg;
    logic signed [BG_W-1:0] bg_reg;
    logic [1:0]             mode_reg;
    logic                   cfg_wr, geom_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb begin
        geom_wr = 1'b0;
        unique case (cfg_index)
            CFG_VOLUME_WIDTH, CFG_VOLUME_HEIGHT,
            CFG_VOLUME_DEPTH, CFG_BRICK_EDGE: geom_wr = cfg_wr;
            default:                          geom_wr = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg.last_x <= RST_LAST_DIM;
            geom_reg.last_y <= RST_LAST_DIM;
            geom_reg.last_z <= RST_LAST_DIM;
            geom_reg.last_e <= RST_LAST_EDGE;
            bg_reg          <= '0;
            mode_reg        <= MODE_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_VOLUME_WIDTH:  geom_reg.last_x <= clamp_dim(cfg_data[10:0]);
                CFG_VOLUME_HEIGHT: geom_reg.last_y <= clamp_dim(cfg_data[10:0]);
                CFG_VOLUME_DEPTH:  geom_reg.last_z <= clamp_dim(cfg_data[10:0]);
                CFG_BRICK_EDGE:    geom_reg.last_e <= clamp_edge(cfg_data[6:0]);
                CFG_BACKGROUND:    bg_reg          <= signed'(cfg_data[BG_W-1:0]);
                CFG_METRIC_MODE:   mode_reg        <= cfg_data[1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------- read stage: scan and memory read ----------------
    logic                         in_acc;
    logic [IDX_W-1:0]             scan_idx;
    scan_tag_t                    scan_tag;

    bmms_scan #(
        .SLAB_BRICKS (SLAB_BRICKS),
        .IDX_W       (IDX_W)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom_reg),
        .clear   (geom_wr),
        .adv     (in_acc),
        .idx     (scan_idx),
        .tag     (scan_tag)
    );

    // ---------------- update stage ----------------
    logic                         b_valid_reg;
    logic [IDX_W-1:0]             b_idx_reg;
    logic signed [VOXEL_BITS-1:0] b_value_reg;
    scan_tag_t                    b_tag_reg;
    logic                         b_stall, b_fire, res_load;
    logic signed [VOXEL_BITS-1:0] new_min, new_max;
    logic                         out_valid_reg;

    // Hold a completing voxel only while the previous result beat still waits.
    assign b_stall  = b_valid_reg && b_tag_reg.done && out_valid_reg && !m_ready;
    assign b_fire   = b_valid_reg && !b_stall;
    assign res_load = b_fire && b_tag_reg.done;
    assign s_ready  = !b_stall;
    assign in_acc   = s_valid && s_ready;

    bmms_store #(
        .SLAB_BRICKS (SLAB_BRICKS),
        .IDX_W       (IDX_W),
        .VOXEL_BITS  (VOXEL_BITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (in_acc),
        .rd_idx    (scan_idx),
        .upd_en    (b_fire),
        .upd_idx   (b_idx_reg),
        .upd_value (b_value_reg),
        .upd_first (b_tag_reg.first),
        .new_min   (new_min),
        .new_max   (new_max)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (in_acc) begin
            b_valid_reg <= 1'b1;
        end else if (b_fire) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            b_idx_reg   <= scan_idx;
            b_value_reg <= s_voxel_value;
            b_tag_reg   <= scan_tag;
        end
    end

    // ---------------- similarity ----------------
    logic signed [CW-1:0] lo_e, hi_e, bg_e, dl_s, dh_s, mid_s;
    logic        [CW-1:0] dl, dh, sim_full;
    logic        [SIM_W-1:0] sim;

    always_comb begin
        lo_e  = CW'(new_min);
        hi_e  = CW'(new_max);
        bg_e  = CW'(bg_reg);
        dl_s  = (lo_e - bg_e) <<< 1;
        dh_s  = (hi_e - bg_e) <<< 1;
        mid_s = lo_e + hi_e - (bg_e <<< 1);
        dl    = dl_s[CW-1] ? CW'(-dl_s) : CW'(dl_s);
        dh    = dh_s[CW-1] ? CW'(-dh_s) : CW'(dh_s);
        case (mode_reg)
            MODE_NEARER:  sim_full = (dl < dh) ? dl : dh;
            MODE_FARTHER: sim_full = (dl > dh) ? dl : dh;
            default:      sim_full = mid_s[CW-1] ? CW'(-mid_s) : CW'(mid_s);
        endcase
        // saturate at the top of the output field
        sim = (sim_full > CW'(SIM_MAX)) ? SIM_MAX : sim_full[SIM_W-1:0];
    end

    // ---------------- output register ----------------
    logic [COORD_W-1:0]           out_x_reg, out_y_reg, out_z_reg;
    logic signed [VOXEL_BITS-1:0] out_min_reg, out_max_reg;
    logic [SIM_W-1:0]             out_sim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            out_x_reg   <= b_tag_reg.org_x;
            out_y_reg   <= b_tag_reg.org_y;
            out_z_reg   <= b_tag_reg.org_z;
            out_min_reg <= new_min;
            out_max_reg <= new_max;
            out_sim_reg <= sim;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_origin_x   = out_x_reg;
    assign m_origin_y   = out_y_reg;
    assign m_origin_z   = out_z_reg;
    assign m_similarity = out_sim_reg;

    // Extremes leave as the low voxel bits, zero padded for narrow voxels.
    generate
        if (VOXEL_BITS >= OUT_VOXEL_W) begin : g_out_trunc
            assign m_min_value = out_min_reg[OUT_VOXEL_W-1:0];
            assign m_max_value = out_max_reg[OUT_VOXEL_W-1:0];
        end else begin : g_out_pad
            assign m_min_value = {{(OUT_VOXEL_W-VOXEL_BITS){1'b0}}, out_min_reg};
            assign m_max_value = {{(OUT_VOXEL_W-VOXEL_BITS){1'b0}}, out_max_reg};
        end
    endgenerate

    // ---------------- assertions ----------------
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_min_reg <= out_max_reg))
        else $error("result beat has min above max");

    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> out_valid_reg)
        else $error("completed brick did not reach the output register");

    a_geom_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && (cfg_index == CFG_VOLUME_WIDTH ||
         cfg_index == CFG_VOLUME_HEIGHT || cfg_index == CFG_VOLUME_DEPTH ||
         cfg_index == CFG_BRICK_EDGE)) |=> scan_tag.first)
        else $error("geometry write did not restart the scan");

endmodule
`default_nettype wire

// ===== dv/tb_brick_min_max_similarity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the brick min/max block with background similarity.
// ----------------------------------------------------------------------------
// Voxel beats come from a queue that the main initial block fills one register
// setting at a time. A clocked driver sends them in random bursts. A clocked
// monitor stalls the result channel on its own pattern and compares every
// result beat with the oldest entry of a queue of expected brick summaries.
// The bench's own brick tracker fills that queue as voxels are accepted.
// Registers are written only while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    import bmms_pkg::*;

    localparam int SLAB_ENTRIES  = 4096;
    localparam int VOXEL_W       = 16;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int SETTLE_CYCLES = 8;       // idle wait after each drain before the next setting
    localparam int DRAIN_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int ERR_PRINT_MAX = 200;
    localparam int TIMEOUT_NS    = 60_000_000;

    // codes the package does not name
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7   = 3'd7;
    localparam logic [1:0]           MODE_MIDPOINT = 2'd0;

    typedef struct packed {
        logic [COORD_W-1:0]            org_x;
        logic [COORD_W-1:0]            org_y;
        logic [COORD_W-1:0]            org_z;
        logic signed [OUT_VOXEL_W-1:0] lo;
        logic signed [OUT_VOXEL_W-1:0] hi;
        logic [SIM_W-1:0]              sim;
    } brick_summary_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic signed [VOXEL_W-1:0]   s_voxel_value = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [COORD_W-1:0]          m_origin_x;
    logic [COORD_W-1:0]          m_origin_y;
    logic [COORD_W-1:0]          m_origin_z;
    logic signed [OUT_VOXEL_W-1:0] m_min_value;
    logic signed [OUT_VOXEL_W-1:0] m_max_value;
    logic [SIM_W-1:0]            m_similarity;
    logic                        cfg_valid     = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index     = '0;
    logic [CFG_DATA_W-1:0]       cfg_data      = '0;

    always #10 aclk = ~aclk;

    brick_min_max_similarity #(
        .SLAB_BRICKS (SLAB_ENTRIES),
        .VOXEL_BITS  (VOXEL_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_voxel_value (s_voxel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_origin_x    (m_origin_x),
        .m_origin_y    (m_origin_y),
        .m_origin_z    (m_origin_z),
        .m_min_value   (m_min_value),
        .m_max_value   (m_max_value),
        .m_similarity  (m_similarity),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the block: registers, raster position and brick extremes.
    // ------------------------------------------------------------------------
    logic [10:0]               reg_width;
    logic [10:0]               reg_height;
    logic [10:0]               reg_depth;
    logic [6:0]                reg_edge;
    logic signed [BG_W-1:0]    reg_background;
    logic [1:0]                reg_mode;

    int unsigned cur_x, cur_y, cur_z;       // raster position in the volume
    int unsigned in_x, in_y, in_z;          // offset inside the current brick
    int unsigned slab_col, slab_row;        // brick counters within the slab

    logic signed [VOXEL_W-1:0] lo_track [SLAB_ENTRIES];
    logic signed [VOXEL_W-1:0] hi_track [SLAB_ENTRIES];

    brick_summary_t            expected_bricks [$];
    logic signed [VOXEL_W-1:0] pending_voxels  [$];

    int error_count   = 0;
    int voxels_in     = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int settings_seen = 0;

    // Zero acts as one, anything above the top acts as the top.
    function automatic int unsigned limit_size(input int unsigned raw, input int unsigned top);
        if (raw == 0) return 1;
        return (raw > top) ? top : raw;
    endfunction

    function automatic void restart_scan();
        cur_x    = 0;
        cur_y    = 0;
        cur_z    = 0;
        in_x     = 0;
        in_y     = 0;
        in_z     = 0;
        slab_col = 0;
        slab_row = 0;
    endfunction

    function automatic void restore_defaults();
        foreach (lo_track[i]) begin
            lo_track[i] = '0;
            hi_track[i] = '0;
        end
        reg_width      = 11'd64;
        reg_height     = 11'd64;
        reg_depth      = 11'd64;
        reg_edge       = 7'd8;
        reg_background = '0;
        reg_mode       = MODE_RESET;
        restart_scan();
    endfunction

    // Geometry writes put the scan back at the origin; the stores keep their data.
    function automatic void apply_register_write(input logic [CFG_IDX_W-1:0] idx,
                                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_VOLUME_WIDTH: begin
                reg_width = data[10:0];
                restart_scan();
            end
            CFG_VOLUME_HEIGHT: begin
                reg_height = data[10:0];
                restart_scan();
            end
            CFG_VOLUME_DEPTH: begin
                reg_depth = data[10:0];
                restart_scan();
            end
            CFG_BRICK_EDGE: begin
                reg_edge = data[6:0];
                restart_scan();
            end
            CFG_BACKGROUND:  reg_background = data;
            CFG_METRIC_MODE: reg_mode = data[1:0];
            default: ;
        endcase
    endfunction

    // Fold one accepted voxel into its brick, queue a summary if the brick is
    // complete, then step the raster position.
    function automatic void predict_voxel(input logic signed [VOXEL_W-1:0] v);
        int unsigned    w, h, d, e, bricks_x, slot;
        bit             opens, last_x, last_y, last_z;
        int             lo, hi, b, dl, dh, s;
        brick_summary_t summary;
        w        = limit_size(reg_width, 1024);
        h        = limit_size(reg_height, 1024);
        d        = limit_size(reg_depth, 1024);
        e        = limit_size(reg_edge, 64);
        bricks_x = (w + e - 1) / e;
        slot     = (slab_row * bricks_x + slab_col) % SLAB_ENTRIES;
        opens    = (in_x == 0) && (in_y == 0) && (in_z == 0);

        if (opens) begin
            lo_track[slot] = v;
            hi_track[slot] = v;
        end else begin
            if (v < lo_track[slot]) lo_track[slot] = v;
            if (v > hi_track[slot]) hi_track[slot] = v;
        end

        last_x = (in_x + 1 >= e) || (cur_x + 1 >= w);
        last_y = (in_y + 1 >= e) || (cur_y + 1 >= h);
        last_z = (in_z + 1 >= e) || (cur_z + 1 >= d);
        if (last_x && last_y && last_z) begin
            lo = lo_track[slot];
            hi = hi_track[slot];
            b  = reg_background;
            dl = 2 * lo - 2 * b;
            dh = 2 * hi - 2 * b;
            if (dl < 0) dl = -dl;
            if (dh < 0) dh = -dh;
            if (reg_mode == MODE_NEARER) begin
                s = (dl < dh) ? dl : dh;
            end else if (reg_mode == MODE_FARTHER) begin
                s = (dl > dh) ? dl : dh;
            end else begin
                s = lo + hi - 2 * b;
                if (s < 0) s = -s;
            end
            if (s > int'(SIM_MAX)) s = int'(SIM_MAX);
            summary.org_x = COORD_W'(cur_x - in_x);
            summary.org_y = COORD_W'(cur_y - in_y);
            summary.org_z = COORD_W'(cur_z - in_z);
            summary.lo    = lo_track[slot];
            summary.hi    = hi_track[slot];
            summary.sim   = SIM_W'(s);
            expected_bricks.push_back(summary);
        end

        if (cur_x + 1 >= w) begin
            cur_x    = 0;
            in_x     = 0;
            slab_col = 0;
            if (cur_y + 1 >= h) begin
                cur_y    = 0;
                in_y     = 0;
                slab_row = 0;
                if (cur_z + 1 >= d) begin
                    cur_z = 0;
                    in_z  = 0;
                end else begin
                    cur_z++;
                    in_z = (in_z + 1 >= e) ? 0 : in_z + 1;
                end
            end else begin
                cur_y++;
                if (in_y + 1 >= e) begin
                    in_y     = 0;
                    slab_row = (slab_row + 1) % 1024;
                end else begin
                    in_y++;
                end
            end
        end else begin
            cur_x++;
            if (in_x + 1 >= e) begin
                in_x     = 0;
                slab_col = (slab_col + 1) % 1024;
            end else begin
                in_x++;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Mix of full-range noise, the two extremes and values near the background.
    function automatic logic signed [VOXEL_W-1:0] make_voxel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return VOXEL_W'($urandom);
        if (pick < 7) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        return reg_background + VOXEL_W'($urandom_range(0, 64)) - 16'sd32;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_background();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Hold the write beat until the block takes it, then update the bench copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register_write(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Bits above each register's width are random; the block must drop them.
    task automatic write_geometry(input int unsigned w, input int unsigned h,
                                  input int unsigned d, input int unsigned e);
        write_reg(CFG_VOLUME_WIDTH,  {5'($urandom_range(0, 31)), 11'(w)});
        write_reg(CFG_VOLUME_HEIGHT, {5'($urandom_range(0, 31)), 11'(h)});
        write_reg(CFG_VOLUME_DEPTH,  {5'($urandom_range(0, 31)), 11'(d)});
        write_reg(CFG_BRICK_EDGE,    {9'($urandom_range(0, 511)), 7'(e)});
    endtask

    // Wait for every voxel to go in and every brick summary to come out, then
    // let the pipeline settle, since a partial brick may still be in flight.
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_voxels.size() != 0 || s_valid) @(posedge aclk);
        while (expected_bricks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_bricks.size() != 0) begin
            error_count++;
            $error("%0d expected brick results never arrived", expected_bricks.size());
            expected_bricks.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_setting(input int unsigned w, input int unsigned h,
                               input int unsigned d, input int unsigned e,
                               input logic [CFG_DATA_W-1:0] bg, input logic [1:0] mode,
                               input int unsigned count, input bit keep_geometry);
        if (!keep_geometry) write_geometry(w, h, d, e);
        write_reg(CFG_BACKGROUND, bg);
        write_reg(CFG_METRIC_MODE, {14'($urandom_range(0, 16383)), mode});
        repeat (count) pending_voxels.push_back(make_voxel());
        settings_seen++;
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Driver: send queued voxels in bursts of random length, with random gaps.
    // A gap only starts once the current beat has been taken.
    // ------------------------------------------------------------------------
    int unsigned               burst_left;
    int unsigned               gap_left;
    logic signed [VOXEL_W-1:0] next_voxel;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_voxel_value <= '0;
            burst_left    = $urandom_range(1, 48);
            gap_left      = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_voxel(s_voxel_value);
                voxels_in++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_voxels.size() != 0) begin
                    next_voxel = pending_voxels.pop_front();
                    s_valid       <= 1'b1;
                    s_voxel_value <= next_voxel;
                    if (burst_left <= 1) begin
                        // new burst; a third of the time run straight on
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result beat, and stall the result channel on a
    // pattern set by a free-running cycle counter. A few times it holds off for a
    // long stretch so the block fills up and drops s_ready.
    // ------------------------------------------------------------------------
    logic [31:0]    rx_cycle;
    int unsigned    hold_left;
    brick_summary_t want;

    task automatic note_mismatch(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            error_count++;
            if (error_count <= ERR_PRINT_MAX)
                $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_cycle  = '0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_bricks.size() == 0) begin
                    error_count++;
                    if (error_count <= ERR_PRINT_MAX)
                        $error("brick result with none expected: origin (%0d,%0d,%0d)",
                               m_origin_x, m_origin_y, m_origin_z);
                end else begin
                    want = expected_bricks.pop_front();
                    note_mismatch("origin_x", want.org_x, m_origin_x);
                    note_mismatch("origin_y", want.org_y, m_origin_y);
                    note_mismatch("origin_z", want.org_z, m_origin_z);
                    note_mismatch("min_value", want.lo, m_min_value);
                    note_mismatch("max_value", want.hi, m_max_value);
                    note_mismatch("similarity", want.sim, m_similarity);
                end
                if (results_seen == 30 || results_seen == 900 || results_seen == 3000)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_cycle[9:7])
                    3'd0, 3'd1: m_ready <= 1'b1;
                    3'd2:       m_ready <= 1'($urandom_range(0, 1));
                    3'd3:       m_ready <= (rx_cycle[2:0] != 3'd5);
                    3'd4:       m_ready <= (rx_cycle[3:0] < 4'd3);   // mostly stalled
                    default:    m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned w, h, d, e, vol, count, random_items;
        bit          keep_geo;
        restore_defaults();
        random_items = 0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // One 2x2x1 brick, reset background and midpoint code; both extremes
        // in one brick.
        write_reg(CFG_VOLUME_WIDTH, 16'd2);
        write_reg(CFG_VOLUME_HEIGHT, 16'd2);
        write_reg(CFG_VOLUME_DEPTH, 16'd1);
        write_reg(CFG_BRICK_EDGE, 16'd2);
        pending_voxels.push_back(16'sh8000);
        pending_voxels.push_back(16'sh7FFF);
        pending_voxels.push_back(16'sd5);
        pending_voxels.push_back(-16'sd7);
        drain();

        // Farther extreme against the lowest background: top of the range.
        write_reg(CFG_BACKGROUND, 16'h8000);
        write_reg(CFG_METRIC_MODE, {14'd0, MODE_FARTHER});
        pending_voxels.push_back(16'sh7FFF);
        pending_voxels.push_back(16'sh8000);
        pending_voxels.push_back(16'sh7FFF);
        pending_voxels.push_back(16'sd0);
        drain();

        // Nearer extreme against the highest background; the volume wraps.
        write_reg(CFG_BACKGROUND, 16'h7FFF);
        write_reg(CFG_METRIC_MODE, {14'd0, MODE_NEARER});
        pending_voxels.push_back(16'sh8000);
        pending_voxels.push_back(16'sd0);
        pending_voxels.push_back(16'sd100);
        pending_voxels.push_back(16'sh7FFF);
        drain();

        // Spare indexes must change nothing. Leave a brick half done, then
        // restart the scan with a geometry write and fill a fresh brick.
        write_reg(CFG_BACKGROUND, 16'hFFFF);
        write_reg(CFG_METRIC_MODE, {14'd0, MODE_MIDPOINT});
        write_reg(CFG_SPARE_6, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'hFFFF);
        pending_voxels.push_back(16'sd100);
        pending_voxels.push_back(16'sd200);
        pending_voxels.push_back(16'sd300);
        drain();
        write_reg(CFG_VOLUME_WIDTH, 16'd2);
        pending_voxels.push_back(-16'sd1);
        pending_voxels.push_back(-16'sd2);
        pending_voxels.push_back(16'sd1);
        pending_voxels.push_back(16'sd2);
        drain();

        // Zero edge acts as one: every voxel is a brick, scan wraps twice.
        write_reg(CFG_VOLUME_HEIGHT, 16'd1);
        write_reg(CFG_BRICK_EDGE, 16'd0);
        pending_voxels.push_back(16'sd7);
        pending_voxels.push_back(16'sh8000);
        pending_voxels.push_back(16'sh7FFF);
        pending_voxels.push_back(16'sd0);
        pending_voxels.push_back(-16'sd3);
        drain();

        // Random settings: mostly small volumes streamed whole, some cut short
        // or carried across a setting, some with clamped sizes.
        while (random_items < RANDOM_ITEMS) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            d = $urandom_range(1, 5);
            e = $urandom_range(1, 5);
            case ($urandom_range(0, 9))
                0: begin
                    w = $urandom_range(13, 70);
                    h = $urandom_range(1, 4);
                    d = $urandom_range(1, 2);
                    e = $urandom_range(6, 64);
                end
                1: e = 0;
                2: e = $urandom_range(65, 127);
                3: begin
                    case ($urandom_range(0, 2))
                        0:       w = 0;
                        1:       h = 0;
                        default: d = 0;
                    endcase
                end
                default: ;
            endcase
            // now and then keep the geometry so the scan carries on mid-brick
            keep_geo = ($urandom_range(0, 7) == 0);
            if (keep_geo)
                vol = limit_size(reg_width, 1024) * limit_size(reg_height, 1024)
                      * limit_size(reg_depth, 1024);
            else
                vol = limit_size(w, 1024) * limit_size(h, 1024) * limit_size(d, 1024);
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, vol + vol / 2 + 1);
            else
                count = vol * $urandom_range(1, 2);
            if (count > 600) count = 600;
            run_setting(w, h, d, e, pick_background(), 2'($urandom_range(0, 3)),
                        count, keep_geo);
            random_items += count;
        end

        // Full-size lines of one-voxel bricks walk every origin bit; then the
        // clamped sizes, and a slab with more bricks than the store holds.
        run_setting(1024, 1, 1, 1, pick_background(), 2'($urandom_range(0, 3)), 1024, 1'b0);
        run_setting(1, 1500, 1, 1, pick_background(), 2'($urandom_range(0, 3)), 1024, 1'b0);
        run_setting(1, 1, 1024, 1, pick_background(), 2'($urandom_range(0, 3)), 1024, 1'b0);
        run_setting(1100, 0, 0, 127, pick_background(), 2'($urandom_range(0, 3)), 1024, 1'b0);
        run_setting(128, 130, 2, 2, pick_background(), 2'($urandom_range(0, 3)),
                    128 * 130 * 2, 1'b0);

        drain();
        $display("Covered %0d voxel beats, %0d brick results, %0d register writes",
                 voxels_in, results_seen, reg_writes);
        $display("over %0d random settings: clamped sizes, scan restarts, slab wrap, all metrics",
                 settings_seen);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
